/* rtl/lab_pkg.sv */
// ----------------------------------------------------------------------------
// lab_pkg
// shared constants and types of the line angle bisector pipeline
// ----------------------------------------------------------------------------
package lab_pkg;

  // default fraction bits of the fixed point coefficients
  localparam int unsigned FRAC_BITS = 16;
  // coefficient width
  localparam int unsigned DW        = 32;
  // normalized magnitude reaches at least 2^NORM_BITS
  localparam int unsigned NORM_BITS = 30;
  // width of a normalization shift count (0 .. NORM_BITS)
  localparam int unsigned SHW       = 5;
  // width of the root of a sum of two squared coefficients
  localparam int unsigned ROOT_W    = 32;

  // one line as it travels through the pipeline
  typedef struct packed {
    logic [DW-1:0]  mag_a;
    logic [DW-1:0]  mag_b;
    logic [DW-1:0]  mag_c;
    logic [SHW-1:0] shift;
    logic           neg_a;
    logic           neg_b;
    logic           neg_c;
  } lab_line_t;

endpackage

/* rtl/line_angle_bisector_select.sv */
// ----------------------------------------------------------------------------
// line_angle_bisector_select
// picks the angle bisector of two lines that lies closest to the y axis
// ----------------------------------------------------------------------------
// Takes one pair of lines per cycle and passes it through the 32-stage square
// root of a^2+b^2 followed by the FRAC_BITS+32-stage restoring dividers that
// scale a, b and c of both lines; four front stages and three back stages
// (sign and sum, cross products, select and saturate) complete the pipeline.
// A stall on the result side holds the whole pipeline.
module line_angle_bisector_select #(
  parameter int unsigned FRAC_BITS = lab_pkg::FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] line1_a_i,
  input  logic [31:0] line1_b_i,
  input  logic [31:0] line1_c_i,
  input  logic [31:0] line2_a_i,
  input  logic [31:0] line2_b_i,
  input  logic [31:0] line2_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] bis_a_o,
  output logic [31:0] bis_b_o,
  output logic [31:0] bis_c_o,
  output logic        chose_sum_o,
  output logic        error_code_o
);

  localparam int unsigned DW  = lab_pkg::DW;
  localparam int unsigned SHW = lab_pkg::SHW;
  localparam int unsigned KW  = lab_pkg::ROOT_W;
  localparam int unsigned QW  = FRAC_BITS + lab_pkg::NORM_BITS + 2;
  localparam int unsigned SV  = QW + 2;
  localparam int unsigned MW  = FRAC_BITS + 2;
  localparam int unsigned LW  = $bits(lab_pkg::lab_line_t);
  localparam logic signed [SV-1:0] SAT_MAX = SV'(64'sd2147483647);
  localparam logic signed [SV-1:0] SAT_MIN = SV'(-64'sd2147483648);

  // magnitude of a two's complement coefficient
  function automatic logic [DW-1:0] mag32(input logic [DW-1:0] x);
    mag32 = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // left shift that brings the larger magnitude to at least 2^NORM_BITS
  function automatic logic [SHW-1:0] norm_shift(input logic [DW-1:0] m);
    logic [SHW-1:0] s;
    s = '0;
    for (int i = 0; i < lab_pkg::NORM_BITS; i++) begin
      if (m[i]) begin
        s = SHW'(lab_pkg::NORM_BITS - i);
      end
    end
    // already large enough, no shift
    if (m[DW-1:lab_pkg::NORM_BITS] != '0) begin
      s = '0;
    end
    return s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SV-1:0] v);
    if (v > SAT_MAX) begin
      return 32'h7fff_ffff;
    end else if (v < SAT_MIN) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [SV-1:0] with_sign(input logic [QW-1:0] q,
                                                     input logic neg);
    logic signed [SV-1:0] v;
    v = $signed(SV'(q));
    return neg ? -v : v;
  endfunction

  function automatic logic [MW-1:0] mag_sv(input logic signed [SV-1:0] v);
    logic signed [SV-1:0] m;
    m = v[SV-1] ? -v : v;
    return m[MW-1:0];
  endfunction

  logic en;
  logic out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: magnitudes, signs and degenerate check
  logic               p1_vld_q;
  lab_pkg::lab_line_t p1_l1_q, p1_l2_q, p1_l1_d, p1_l2_d;
  logic               p1_err_q, p1_err_d;

  always_comb begin
    p1_l1_d = '{mag_a: mag32(line1_a_i), mag_b: mag32(line1_b_i),
                mag_c: mag32(line1_c_i), shift: '0, neg_a: line1_a_i[DW-1],
                neg_b: line1_b_i[DW-1], neg_c: line1_c_i[DW-1]};
    p1_l2_d = '{mag_a: mag32(line2_a_i), mag_b: mag32(line2_b_i),
                mag_c: mag32(line2_c_i), shift: '0, neg_a: line2_a_i[DW-1],
                neg_b: line2_b_i[DW-1], neg_c: line2_c_i[DW-1]};
    p1_err_d = (line1_a_i == '0 && line1_b_i == '0) ||
               (line2_a_i == '0 && line2_b_i == '0);
  end

  // stage 2: normalization shift
  logic               p2_vld_q;
  lab_pkg::lab_line_t p2_l1_q, p2_l2_q, p2_l1_d, p2_l2_d;
  logic               p2_err_q;

  always_comb begin
    p2_l1_d       = p1_l1_q;
    p2_l1_d.shift = norm_shift((p1_l1_q.mag_a > p1_l1_q.mag_b) ?
                               p1_l1_q.mag_a : p1_l1_q.mag_b);
    p2_l1_d.mag_a = p1_l1_q.mag_a << p2_l1_d.shift;
    p2_l1_d.mag_b = p1_l1_q.mag_b << p2_l1_d.shift;
    p2_l2_d       = p1_l2_q;
    p2_l2_d.shift = norm_shift((p1_l2_q.mag_a > p1_l2_q.mag_b) ?
                               p1_l2_q.mag_a : p1_l2_q.mag_b);
    p2_l2_d.mag_a = p1_l2_q.mag_a << p2_l2_d.shift;
    p2_l2_d.mag_b = p1_l2_q.mag_b << p2_l2_d.shift;
  end

  // stage 3: squares
  logic               p3_vld_q;
  lab_pkg::lab_line_t p3_l1_q, p3_l2_q;
  logic               p3_err_q;
  logic [2*DW-1:0]    p3_sqa1_q, p3_sqb1_q, p3_sqa2_q, p3_sqb2_q;

  // stage 4: sum of squares
  logic               p4_vld_q;
  lab_pkg::lab_line_t p4_l1_q, p4_l2_q;
  logic               p4_err_q;
  logic [2*DW-1:0]    p4_rad1_q, p4_rad2_q;

  // front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= in_valid_i;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
    end
  end

  // front stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_l1_q   <= p1_l1_d;
      p1_l2_q   <= p1_l2_d;
      p1_err_q  <= p1_err_d;
      p2_l1_q   <= p2_l1_d;
      p2_l2_q   <= p2_l2_d;
      p2_err_q  <= p1_err_q;
      p3_l1_q   <= p2_l1_q;
      p3_l2_q   <= p2_l2_q;
      p3_err_q  <= p2_err_q;
      p3_sqa1_q <= p2_l1_q.mag_a * p2_l1_q.mag_a;
      p3_sqb1_q <= p2_l1_q.mag_b * p2_l1_q.mag_b;
      p3_sqa2_q <= p2_l2_q.mag_a * p2_l2_q.mag_a;
      p3_sqb2_q <= p2_l2_q.mag_b * p2_l2_q.mag_b;
      p4_l1_q   <= p3_l1_q;
      p4_l2_q   <= p3_l2_q;
      p4_err_q  <= p3_err_q;
      p4_rad1_q <= p3_sqa1_q + p3_sqb1_q;
      p4_rad2_q <= p3_sqa2_q + p3_sqb2_q;
    end
  end

  // square roots of both lines
  logic               k1_vld, k2_vld;
  logic [KW-1:0]      k1_root, k2_root;
  logic [LW:0]        k1_side;
  logic [LW-1:0]      k2_side;
  lab_pkg::lab_line_t k1_l, k2_l;
  logic               k1_err;

  lab_isqrt #(.SIDE_W(LW + 1)) u_isqrt1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p4_vld_q), .rad_i(p4_rad1_q),
    .side_i({p4_err_q, p4_l1_q}), .valid_o(k1_vld), .root_o(k1_root),
    .side_o(k1_side)
  );

  lab_isqrt #(.SIDE_W(LW)) u_isqrt2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p4_vld_q), .rad_i(p4_rad2_q),
    .side_i(p4_l2_q), .valid_o(k2_vld), .root_o(k2_root), .side_o(k2_side)
  );

  assign {k1_err, k1_l} = k1_side;
  assign k2_l           = k2_side;

  // scaling of each coefficient by its line's root
  logic [QW-1:0] qa1, qb1, qc1, qa2, qb2, qc2;
  logic [1:0]    sa1;
  logic          sb1, sc1, sa2, sb2, sc2;
  logic          q_vld;
  logic          va_unused_b1, va_unused_c1, va_unused_a2, va_unused_b2, va_unused_c2;

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2)) u_div_a1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k1_vld), .num_i(k1_l.mag_a),
    .den_i(k1_root), .sh_i(SHW'(lab_pkg::NORM_BITS)),
    .side_i({k1_err, k1_l.neg_a}), .valid_o(q_vld), .q_o(qa1), .side_o(sa1)
  );

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_b1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k1_vld), .num_i(k1_l.mag_b),
    .den_i(k1_root), .sh_i(SHW'(lab_pkg::NORM_BITS)), .side_i(k1_l.neg_b),
    .valid_o(va_unused_b1), .q_o(qb1), .side_o(sb1)
  );

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_c1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k1_vld), .num_i(k1_l.mag_c),
    .den_i(k1_root), .sh_i(SHW'(lab_pkg::NORM_BITS) - k1_l.shift),
    .side_i(k1_l.neg_c), .valid_o(va_unused_c1), .q_o(qc1), .side_o(sc1)
  );

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_a2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k2_vld), .num_i(k2_l.mag_a),
    .den_i(k2_root), .sh_i(SHW'(lab_pkg::NORM_BITS)), .side_i(k2_l.neg_a),
    .valid_o(va_unused_a2), .q_o(qa2), .side_o(sa2)
  );

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_b2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k2_vld), .num_i(k2_l.mag_b),
    .den_i(k2_root), .sh_i(SHW'(lab_pkg::NORM_BITS)), .side_i(k2_l.neg_b),
    .valid_o(va_unused_b2), .q_o(qb2), .side_o(sb2)
  );

  lab_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_c2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(k2_vld), .num_i(k2_l.mag_c),
    .den_i(k2_root), .sh_i(SHW'(lab_pkg::NORM_BITS) - k2_l.shift),
    .side_i(k2_l.neg_c), .valid_o(va_unused_c2), .q_o(qc2), .side_o(sc2)
  );

  // back stage 1: signed terms, difference and sum bisectors
  logic                 p5_vld_q, p5_err_q;
  logic signed [SV-1:0] p5_da_q, p5_db_q, p5_dc_q, p5_sa_q, p5_sb_q, p5_sc_q;
  logic signed [SV-1:0] na1, nb1, nc1, na2, nb2, nc2;

  always_comb begin
    na1 = with_sign(qa1, sa1[0]);
    nb1 = with_sign(qb1, sb1);
    nc1 = with_sign(qc1, sc1);
    na2 = with_sign(qa2, sa2);
    nb2 = with_sign(qb2, sb2);
    nc2 = with_sign(qc2, sc2);
  end

  // back stage 2: cross products of the direction magnitudes
  logic                 p6_vld_q, p6_err_q;
  logic signed [SV-1:0] p6_da_q, p6_db_q, p6_dc_q, p6_sa_q, p6_sb_q, p6_sc_q;
  logic [2*MW-1:0]      p6_pd_q, p6_ps_q;
  logic                 p6_dz_q, p6_sz_q;

  // back stage 3: selection and saturation into the output register
  logic        take_sum;
  logic [31:0] bis_a_q, bis_b_q, bis_c_q;
  logic        chose_q, err_q;

  always_comb begin
    if (p6_dz_q) begin
      take_sum = !p6_sz_q;
    end else if (p6_sz_q) begin
      take_sum = 1'b0;
    end else begin
      take_sum = (p6_pd_q < p6_ps_q);
    end
  end

  // back stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p5_vld_q  <= q_vld;
      p6_vld_q  <= p5_vld_q;
      out_vld_q <= p6_vld_q;
    end
  end

  // back stage data
  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_err_q <= sa1[1];
      p5_da_q  <= na1 - na2;
      p5_db_q  <= nb1 - nb2;
      p5_dc_q  <= nc1 - nc2;
      p5_sa_q  <= na1 + na2;
      p5_sb_q  <= nb1 + nb2;
      p5_sc_q  <= nc1 + nc2;
      p6_err_q <= p5_err_q;
      p6_da_q  <= p5_da_q;
      p6_db_q  <= p5_db_q;
      p6_dc_q  <= p5_dc_q;
      p6_sa_q  <= p5_sa_q;
      p6_sb_q  <= p5_sb_q;
      p6_sc_q  <= p5_sc_q;
      p6_pd_q  <= mag_sv(p5_da_q) * mag_sv(p5_sb_q);
      p6_ps_q  <= mag_sv(p5_sa_q) * mag_sv(p5_db_q);
      p6_dz_q  <= (p5_da_q == '0) && (p5_db_q == '0);
      p6_sz_q  <= (p5_sa_q == '0) && (p5_sb_q == '0);
      if (p6_err_q) begin
        bis_a_q <= '0;
        bis_b_q <= '0;
        bis_c_q <= '0;
        chose_q <= 1'b0;
        err_q   <= 1'b1;
      end else begin
        bis_a_q <= sat32(take_sum ? p6_sa_q : p6_da_q);
        bis_b_q <= sat32(take_sum ? p6_sb_q : p6_db_q);
        bis_c_q <= sat32(take_sum ? p6_sc_q : p6_dc_q);
        chose_q <= take_sum;
        err_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign bis_a_o      = bis_a_q;
  assign bis_b_o      = bis_b_q;
  assign bis_c_o      = bis_c_q;
  assign chose_sum_o  = chose_q;
  assign error_code_o = err_q;

endmodule

/* rtl/lab_isqrt.sv */
// ----------------------------------------------------------------------------
// lab_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module lab_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2*lab_pkg::ROOT_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [lab_pkg::ROOT_W-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned NST = lab_pkg::ROOT_W;
  localparam int unsigned VW  = 2 * NST;
  localparam int unsigned RW  = NST + 4;

  logic [RW-1:0]     rem_q  [NST];
  logic [RW-1:0]     rem_d  [NST];
  logic [NST-1:0]    root_q [NST];
  logic [NST-1:0]    root_d [NST];
  logic [VW-1:0]     rad_q  [NST];
  logic [VW-1:0]     rad_d  [NST];
  logic [SIDE_W-1:0] side_q [NST];
  logic [SIDE_W-1:0] side_d [NST];
  logic [NST-1:0]    vld_q;

  // one trial subtraction per stage
  always_comb begin
    logic [RW-1:0]     rem_in;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic [NST-1:0]    root_in;
    logic [VW-1:0]     rad_in;
    logic              ge;
    for (int i = 0; i < NST; i++) begin
      if (i == 0) begin
        rem_in    = '0;
        root_in   = '0;
        rad_in    = rad_i;
        side_d[i] = side_i;
      end else begin
        rem_in    = rem_q[i-1];
        root_in   = root_q[i-1];
        rad_in    = rad_q[i-1];
        side_d[i] = side_q[i-1];
      end
      rem_sh    = {rem_in[RW-3:0], rad_in[VW-1 -: 2]};
      trial     = RW'({root_in, 2'b01});
      ge        = (rem_sh >= trial);
      rem_d[i]  = ge ? (rem_sh - trial) : rem_sh;
      root_d[i] = {root_in[NST-2:0], ge};
      rad_d[i]  = rad_in << 2;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NST; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        rad_q[i]  <= rad_d[i];
        side_q[i] <= side_d[i];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

/* rtl/lab_div.sv */
// ----------------------------------------------------------------------------
// lab_div
// pipelined restoring divider: floor(num * 2^(FRAC_BITS+NORM_BITS) / den) >> sh
// ----------------------------------------------------------------------------
module lab_div #(
  parameter int unsigned FRAC_BITS = lab_pkg::FRAC_BITS,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           valid_i,
  input  logic [lab_pkg::DW-1:0]                         num_i,
  input  logic [lab_pkg::ROOT_W-1:0]                     den_i,
  input  logic [lab_pkg::SHW-1:0]                        sh_i,
  input  logic [SIDE_W-1:0]                              side_i,
  output logic                                           valid_o,
  output logic [FRAC_BITS+lab_pkg::NORM_BITS+1:0]        q_o,
  output logic [SIDE_W-1:0]                              side_o
);

  localparam int unsigned NF  = FRAC_BITS + lab_pkg::NORM_BITS;
  localparam int unsigned QW  = NF + 2;
  localparam int unsigned KW  = lab_pkg::ROOT_W;
  localparam int unsigned SHW = lab_pkg::SHW;
  localparam int unsigned NST = NF + 2;

  logic [NST-1:0]    vld_q;

  logic [KW-1:0]     r0_q;
  logic [QW-1:0]     q0_q;
  logic [KW-1:0]     den0_q;
  logic [SHW-1:0]    sh0_q;
  logic [SIDE_W-1:0] side0_q;

  logic [KW-1:0]     r_q    [NF];
  logic [KW-1:0]     r_d    [NF];
  logic [QW-1:0]     q_q    [NF];
  logic [QW-1:0]     q_d    [NF];
  logic [KW-1:0]     den_q  [NF];
  logic [KW-1:0]     den_d  [NF];
  logic [SHW-1:0]    sh_q   [NF];
  logic [SHW-1:0]    sh_d   [NF];
  logic [SIDE_W-1:0] side_q [NF];
  logic [SIDE_W-1:0] side_d [NF];

  logic [QW-1:0]     qo_q;
  logic [SIDE_W-1:0] sideo_q;

  logic [KW:0]       num_x;
  logic [KW:0]       den_x1;
  logic [KW:0]       den_x2;
  logic [KW-1:0]     r0_d;
  logic [QW-1:0]     q0_d;

  // integer part of the quotient is 0, 1 or 2
  always_comb begin
    num_x  = {1'b0, num_i};
    den_x1 = {1'b0, den_i};
    den_x2 = {den_i, 1'b0};
    if (num_x >= den_x2) begin
      q0_d = QW'(2'd2);
      r0_d = KW'(num_x - den_x2);
    end else if (num_x >= den_x1) begin
      q0_d = QW'(2'd1);
      r0_d = KW'(num_x - den_x1);
    end else begin
      q0_d = '0;
      r0_d = num_i;
    end
  end

  // one fraction bit per stage
  always_comb begin
    logic [KW-1:0]  r_in;
    logic [QW-1:0]  q_in;
    logic [KW:0]    r_sh;
    logic [KW:0]    den_w;
    logic           ge;
    for (int i = 0; i < NF; i++) begin
      if (i == 0) begin
        r_in      = r0_q;
        q_in      = q0_q;
        den_d[i]  = den0_q;
        sh_d[i]   = sh0_q;
        side_d[i] = side0_q;
      end else begin
        r_in      = r_q[i-1];
        q_in      = q_q[i-1];
        den_d[i]  = den_q[i-1];
        sh_d[i]   = sh_q[i-1];
        side_d[i] = side_q[i-1];
      end
      r_sh   = {r_in, 1'b0};
      den_w  = {1'b0, den_d[i]};
      ge     = (r_sh >= den_w);
      r_d[i] = ge ? KW'(r_sh - den_w) : r_sh[KW-1:0];
      q_d[i] = {q_in[QW-2:0], ge};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // stage data, final stage drops the unwanted fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q    <= r0_d;
      q0_q    <= q0_d;
      den0_q  <= den_i;
      sh0_q   <= sh_i;
      side0_q <= side_i;
      for (int i = 0; i < NF; i++) begin
        r_q[i]    <= r_d[i];
        q_q[i]    <= q_d[i];
        den_q[i]  <= den_d[i];
        sh_q[i]   <= sh_d[i];
        side_q[i] <= side_d[i];
      end
      qo_q    <= q_q[NF-1] >> sh_q[NF-1];
      sideo_q <= side_q[NF-1];
    end
  end

  assign valid_o = vld_q[NST-1];
  assign q_o     = qo_q;
  assign side_o  = sideo_q;

endmodule
